// ----- sv/bdf_pkg.sv -----
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types and codes for the broadcast duplicate filter.
// ----------------------------------------------------------------------------
package bdf_pkg;

  localparam int ADDR_W  = 32;
  localparam int ID_W    = 16;
  localparam int TTL_W   = 8;
  localparam int LIFE_W  = 16;
  localparam int SEC_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int KEY_W   = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME   = 2'd2;

  localparam logic [ADDR_W-1:0] BCAST_RESET    = '1;
  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd120;

  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_DELIVER = 2'd1,
    ACT_DEL_FWD = 2'd2,
    ACT_FORWARD = 2'd3
  } action_t;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_HASH   = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  // one seen-table entry
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] source;
    logic [ID_W-1:0]   id;
    logic [SEC_W-1:0]  stamp;
  } entry_t;

endpackage

// ----- sv/broadcast_duplicate_filter_unit.sv -----
// ----------------------------------------------------------------------------
// broadcast_duplicate_filter_unit
// Classifies layer-3 headers and drops repeated broadcasts via a hashed,
// set-associative seen-table with per-entry lifetime.
// ----------------------------------------------------------------------------
// Usage: pulse start with a transaction while busy is low. Ticks, unicast
// headers and headers for this node leave busy low: done strobes in
// the next cycle and a new transaction may be started in that same cycle.
// A broadcast header walks the WAYS ways of its bucket through one table
// read port and one shared compare/age unit, one way per cycle, then
// writes the chosen way: busy stays high from acceptance until that write,
// so a new transaction is taken no earlier than the broadcast's done strobe.
// When BUCKETS is not a power of two the bucket index comes from a
// reciprocal multiply, a multiply-back and one conditional subtract,
// registered in turn before the scan. The result is shown for exactly
// one cycle with done; there is no backpressure, so the receiver must
// take it then. After reset all BUCKETS*WAYS table entries (1024 by
// default) are cleared one entry per cycle with busy high;
// configuration writes are taken at any time, but are meant for idle.
// ----------------------------------------------------------------------------
module broadcast_duplicate_filter_unit #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [bdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdf_pkg::ADDR_W-1:0]       cfg_data,
  // command
  input  logic                             start,
  output logic                             busy,
  input  logic                             command,
  input  logic [bdf_pkg::ADDR_W-1:0]       dst_address,
  input  logic [bdf_pkg::ADDR_W-1:0]       src_address,
  input  logic [bdf_pkg::ID_W-1:0]         header_id,
  input  logic [bdf_pkg::TTL_W-1:0]        hop_limit,
  // result
  output logic                             done,
  output logic [1:0]                       action,
  output logic [bdf_pkg::TTL_W-1:0]        out_hop_limit
);

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW      = $clog2(BUCKETS);
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCW     = $clog2(WAYS + 1);
  localparam int EW      = $bits(bdf_pkg::entry_t);
  localparam int KW      = bdf_pkg::KEY_W;
  localparam bit POW2    = (BUCKETS & (BUCKETS - 1)) == 0;
  // floor(2^32 / BUCKETS): quotient estimate is exact or one low
  localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / BUCKETS);

  // configuration registers
  logic [bdf_pkg::ADDR_W-1:0] node_address;
  logic [bdf_pkg::ADDR_W-1:0] broadcast_address;
  logic [bdf_pkg::LIFE_W-1:0] entry_lifetime;

  bdf_pkg::state_t state;
  logic [bdf_pkg::SEC_W-1:0] seconds_now;

  // current transaction
  logic [bdf_pkg::ADDR_W-1:0] key_src;
  logic [bdf_pkg::ID_W-1:0]   key_id;
  logic [bdf_pkg::TTL_W-1:0]  key_ttl;
  logic [BW-1:0]              bucket;

  // key mod BUCKETS for non power-of-two bucket counts
  logic [KW-1:0]              hkey;
  logic [2*KW-1:0]            hprod;
  logic [KW-1:0]              hq;
  logic [KW-1:0]              hmul;
  logic [KW-1:0]              hrem;
  logic [KW-1:0]              hrem_fix;
  logic [1:0]                 hcnt;

  // way scan
  logic [WCW-1:0]             rd_way;
  logic [WW-1:0]              ev_way;
  logic                       ev_valid;
  logic                       m_hit;
  logic                       m_live;
  logic [WW-1:0]              m_way;
  logic                       f_have;
  logic [WW-1:0]              f_way;
  logic [bdf_pkg::SEC_W-1:0]  o_age;
  logic [WW-1:0]              o_way;

  // table
  logic [EW-1:0]              mem [ENTRIES];
  logic [EW-1:0]              rd_data;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [EW-1:0]              mem_wdata;
  logic [AW-1:0]              clr_addr;

  bdf_pkg::entry_t            ev_entry;
  bdf_pkg::entry_t            fresh_entry;
  logic [bdf_pkg::SEC_W-1:0]  ev_age;
  logic                       ev_match;
  logic                       dup;
  logic [WW-1:0]              victim_way;
  logic [bdf_pkg::KEY_W-1:0]  in_key;

  assign busy = (state != bdf_pkg::ST_IDLE);

  assign in_key = src_address ^ {{(bdf_pkg::KEY_W - bdf_pkg::ID_W){1'b0}}, header_id};

  // Barrett-style remainder: q = (key * RECIP) >> 32, r = key - q*BUCKETS,
  // r is below 2*BUCKETS, so one conditional subtract finishes it
  assign hprod    = {{KW{1'b0}}, hkey} * {{KW{1'b0}}, RECIP};
  assign hmul     = hq * KW'(BUCKETS);
  assign hrem_fix = (hrem >= KW'(BUCKETS)) ? hrem - KW'(BUCKETS) : hrem;

  // shared compare / age unit
  assign ev_entry = bdf_pkg::entry_t'(rd_data);
  assign ev_age   = seconds_now - ev_entry.stamp;
  assign ev_match = ev_entry.valid && (ev_entry.source == key_src) && (ev_entry.id == key_id);

  assign dup        = m_hit && m_live;
  assign victim_way = m_hit ? m_way : (f_have ? f_way : o_way);

  assign fresh_entry.valid  = 1'b1;
  assign fresh_entry.source = key_src;
  assign fresh_entry.id     = key_id;
  assign fresh_entry.stamp  = seconds_now;

  assign mem_re    = (state == bdf_pkg::ST_SCAN) && (rd_way < WCW'(WAYS));
  assign mem_raddr = AW'(bucket) * AW'(WAYS) + AW'(rd_way[WW-1:0]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == bdf_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == bdf_pkg::ST_COMMIT) begin
      mem_we    = !dup;
      mem_waddr = AW'(bucket) * AW'(WAYS) + AW'(victim_way);
      mem_wdata = fresh_entry;
    end
  end

  // table ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address      <= '0;
      broadcast_address <= bdf_pkg::BCAST_RESET;
      entry_lifetime    <= bdf_pkg::LIFETIME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bdf_pkg::REG_NODE_ADDR:  node_address      <= cfg_data;
        bdf_pkg::REG_BCAST_ADDR: broadcast_address <= cfg_data;
        bdf_pkg::REG_LIFETIME:   entry_lifetime    <= cfg_data[bdf_pkg::LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bdf_pkg::ST_CLEAR;
      seconds_now <= '0;
      clr_addr    <= '0;
      done        <= 1'b0;
      ev_valid    <= 1'b0;
      rd_way      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        bdf_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(ENTRIES - 1)) begin
            state <= bdf_pkg::ST_IDLE;
          end
        end

        bdf_pkg::ST_IDLE: begin
          if (start) begin
            key_src  <= src_address;
            key_id   <= header_id;
            key_ttl  <= hop_limit;
            rd_way   <= '0;
            ev_valid <= 1'b0;
            m_hit    <= 1'b0;
            m_live   <= 1'b0;
            f_have   <= 1'b0;
            o_age    <= '0;
            hkey     <= in_key;
            hrem     <= '0;
            hcnt     <= '0;
            action        <= bdf_pkg::ACT_DROP;
            out_hop_limit <= '0;
            if (command == bdf_pkg::CMD_TICK) begin
              seconds_now <= seconds_now + 1'b1;
              done        <= 1'b1;
            end else if (dst_address == node_address) begin
              action <= bdf_pkg::ACT_DELIVER;
              done   <= 1'b1;
            end else if (dst_address == broadcast_address) begin
              if (POW2) begin
                bucket <= in_key[BW-1:0];
                state  <= bdf_pkg::ST_SCAN;
              end else begin
                state  <= bdf_pkg::ST_HASH;
              end
            end else begin
              if (hop_limit > 8'd1) begin
                action        <= bdf_pkg::ACT_FORWARD;
                out_hop_limit <= hop_limit - 1'b1;
              end
              done <= 1'b1;
            end
          end
        end

        bdf_pkg::ST_HASH: begin
          hcnt <= hcnt + 1'b1;
          case (hcnt)
            2'd0: hq <= hprod[2*KW-1:KW];
            2'd1: hrem <= hkey - hmul;
            default: begin
              bucket <= hrem_fix[BW-1:0];
              state  <= bdf_pkg::ST_SCAN;
            end
          endcase
        end

        bdf_pkg::ST_SCAN: begin
          // read way rd_way while evaluating the previous way
          if (mem_re) begin
            rd_way   <= rd_way + 1'b1;
            ev_way   <= rd_way[WW-1:0];
            ev_valid <= 1'b1;
          end else begin
            ev_valid <= 1'b0;
          end
          if (ev_valid) begin
            if (ev_match && !m_hit) begin
              m_hit  <= 1'b1;
              m_way  <= ev_way;
              m_live <= ev_age <= {{(bdf_pkg::SEC_W - bdf_pkg::LIFE_W){1'b0}}, entry_lifetime};
            end
            if (!ev_entry.valid) begin
              if (!f_have) begin
                f_have <= 1'b1;
                f_way  <= ev_way;
              end
            end else if (ev_way == '0 || ev_age > o_age) begin
              o_age <= ev_age;
              o_way <= ev_way;
            end
            if (ev_way == WW'(WAYS - 1)) begin
              state <= bdf_pkg::ST_COMMIT;
            end
          end
        end

        bdf_pkg::ST_COMMIT: begin
          // table write, skipped for a live duplicate, goes through the write port this cycle
          if (!dup && key_ttl > 8'd1) begin
            action        <= bdf_pkg::ACT_DEL_FWD;
            out_hop_limit <= key_ttl - 1'b1;
          end
          done  <= 1'b1;
          state <= bdf_pkg::ST_IDLE;
        end

        default: state <= bdf_pkg::ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // an accepted transaction either finishes next cycle or keeps the unit busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor done");

  // scan pipeline is drained by the time the table is written
  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == bdf_pkg::ST_COMMIT) |-> !ev_valid)
    else $error("way evaluation still pending at commit");

  // forwarded hop limit comes from a hop limit above one
  a_fwd_ttl: assert property (@(posedge clk) disable iff (rst)
    (done && (action == bdf_pkg::ACT_DEL_FWD || action == bdf_pkg::ACT_FORWARD))
      |-> (out_hop_limit != '0 && out_hop_limit != '1))
    else $error("bad forwarded hop limit");

  // non-forwarding results carry a zero hop limit
  a_nofwd_ttl: assert property (@(posedge clk) disable iff (rst)
    (done && (action == bdf_pkg::ACT_DROP || action == bdf_pkg::ACT_DELIVER))
      |-> (out_hop_limit == '0))
    else $error("hop limit set on non-forwarding result");

endmodule

// ----- verif/broadcast_duplicate_filter_unit_test.sv -----
// ----------------------------------------------------------------------------
// broadcast_duplicate_filter_unit_test
// Self-checking bench for the duplicate broadcast filter: drives header and
// tick transactions through the start/busy port, mirrors the seen-table in
// a scoreboard model and checks every done strobe against it.
// ----------------------------------------------------------------------------
module broadcast_duplicate_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int POOL_N  = 24;   // (src, id) pairs reused to provoke hits
  localparam int POOL_BK = 3;    // buckets the pool is packed into

  // index 3 has no register behind it; writes there must be ignored
  localparam logic [bdf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one input transaction
  typedef struct {
    logic                       cmd;
    logic [bdf_pkg::ADDR_W-1:0] dst;
    logic [bdf_pkg::ADDR_W-1:0] src;
    logic [bdf_pkg::ID_W-1:0]   id;
    logic [bdf_pkg::TTL_W-1:0]  hops;
  } hdr_item_t;

  // what the block should say about one transaction
  typedef struct {
    bdf_pkg::action_t          act;
    logic [bdf_pkg::TTL_W-1:0] hops;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of config, seconds clock and seen-table. Each
  // accepted transaction is classified here and its verdict queued; each
  // done strobe is checked against the oldest queued verdict.
  // --------------------------------------------------------------------------
  class seen_table_tracker;
    logic [bdf_pkg::ADDR_W-1:0] own_addr;
    logic [bdf_pkg::ADDR_W-1:0] bcast_addr;
    logic [bdf_pkg::LIFE_W-1:0] lifetime;
    logic [bdf_pkg::SEC_W-1:0]  secs;
    bit                         ent_valid [ENTRIES];
    logic [bdf_pkg::ADDR_W-1:0] ent_src   [ENTRIES];
    logic [bdf_pkg::ID_W-1:0]   ent_id    [ENTRIES];
    logic [bdf_pkg::SEC_W-1:0]  ent_stamp [ENTRIES];
    verdict_t                   expected_verdicts [$];
    int                         errors;

    function new();
      own_addr   = '0;
      bcast_addr = bdf_pkg::BCAST_RESET;
      lifetime   = bdf_pkg::LIFETIME_RESET;
      secs       = '0;
      errors     = 0;
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    endfunction

    function void set_reg(logic [bdf_pkg::CFG_IDX_W-1:0] idx,
                          logic [bdf_pkg::ADDR_W-1:0] data);
      case (idx)
        bdf_pkg::REG_NODE_ADDR:  own_addr   = data;
        bdf_pkg::REG_BCAST_ADDR: bcast_addr = data;
        bdf_pkg::REG_LIFETIME:   lifetime   = data[bdf_pkg::LIFE_W-1:0];
        default: ;
      endcase
    endfunction

    // true when the pair is still live; otherwise it gets (re)recorded
    function bit seen_recently(logic [bdf_pkg::ADDR_W-1:0] src,
                               logic [bdf_pkg::ID_W-1:0] id);
      logic [bdf_pkg::KEY_W-1:0] key;
      logic [bdf_pkg::SEC_W-1:0] age;
      logic [bdf_pkg::SEC_W-1:0] oldest_age;
      int base;
      int victim;
      int oldest;
      bit have_free;
      key = src ^ {{(bdf_pkg::KEY_W-bdf_pkg::ID_W){1'b0}}, id};
      base = int'(key % BUCKETS) * WAYS;
      have_free = 1'b0;
      victim = base;
      oldest = base;
      oldest_age = '0;
      // hit: live means duplicate, expired gets its stamp refreshed in place
      for (int w = 0; w < WAYS; w++) begin
        if (ent_valid[base+w] && ent_src[base+w] == src && ent_id[base+w] == id) begin
          age = secs - ent_stamp[base+w];
          if (age <= {{(bdf_pkg::SEC_W-bdf_pkg::LIFE_W){1'b0}}, lifetime}) return 1'b1;
          ent_stamp[base+w] = secs;
          return 1'b0;
        end
      end
      // miss: lowest free way, else oldest way (lowest on ties)
      for (int w = 0; w < WAYS; w++) begin
        if (!ent_valid[base+w]) begin
          if (!have_free) begin
            have_free = 1'b1;
            victim = base + w;
          end
        end else begin
          age = secs - ent_stamp[base+w];
          if (w == 0 || age > oldest_age) begin
            oldest_age = age;
            oldest = base + w;
          end
        end
      end
      if (!have_free) victim = oldest;
      ent_valid[victim] = 1'b1;
      ent_src[victim]   = src;
      ent_id[victim]    = id;
      ent_stamp[victim] = secs;
      return 1'b0;
    endfunction

    function void note_header(hdr_item_t it);
      verdict_t v;
      v.act  = bdf_pkg::ACT_DROP;
      v.hops = '0;
      if (it.cmd == bdf_pkg::CMD_TICK) begin
        secs = secs + 1'b1;
      end else if (it.dst == own_addr) begin
        v.act = bdf_pkg::ACT_DELIVER;
      end else if (it.dst == bcast_addr) begin
        if (!seen_recently(it.src, it.id) && it.hops > 1) begin
          v.act  = bdf_pkg::ACT_DEL_FWD;
          v.hops = it.hops - 1'b1;
        end
      end else if (it.hops > 1) begin
        v.act  = bdf_pkg::ACT_FORWARD;
        v.hops = it.hops - 1'b1;
      end
      expected_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [1:0] act, logic [bdf_pkg::TTL_W-1:0] hops);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, action %0d hop limit %0d", $time, act, hops);
        errors++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (act !== v.act) begin
        $display("%0t: action mismatch, expected %0d actual %0d", $time, v.act, act);
        errors++;
      end
      if (hops !== v.hops) begin
        $display("%0t: out_hop_limit mismatch, expected %0d actual %0d",
                 $time, v.hops, hops);
        errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          cfg_write   = 1'b0;
  logic [bdf_pkg::CFG_IDX_W-1:0] cfg_index   = bdf_pkg::REG_NODE_ADDR;
  logic [bdf_pkg::ADDR_W-1:0]    cfg_data    = '0;
  logic                          start       = 1'b0;
  logic                          busy;
  logic                          command     = bdf_pkg::CMD_HEADER;
  logic [bdf_pkg::ADDR_W-1:0]    dst_address = '0;
  logic [bdf_pkg::ADDR_W-1:0]    src_address = '0;
  logic [bdf_pkg::ID_W-1:0]      header_id   = '0;
  logic [bdf_pkg::TTL_W-1:0]     hop_limit   = '0;
  logic                          done;
  logic [1:0]                    action;
  logic [bdf_pkg::TTL_W-1:0]     out_hop_limit;

  broadcast_duplicate_filter_unit #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .dst_address   (dst_address),
    .src_address   (src_address),
    .header_id     (header_id),
    .hop_limit     (hop_limit),
    .done          (done),
    .action        (action),
    .out_hop_limit (out_hop_limit)
  );

  seen_table_tracker tracker = new();

  // pairs reused across a phase, packed into a few buckets so that ways
  // fill up, get evicted and get hit again
  logic [bdf_pkg::ADDR_W-1:0] pool_src [POOL_N];
  logic [bdf_pkg::ID_W-1:0]   pool_id  [POOL_N];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off: sample done at every edge. Sampling at the
  // edge reads the values of the cycle that the edge closes.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_verdict(action, out_hop_limit);
  end

  // Slowest legal run is the clearing pass plus ~1k transactions, each a
  // broadcast followed by the longest idle gap; allow ~8x that.
  initial begin
    #2_000_000;
    $display("broadcast_duplicate_filter_unit_test: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Present one transaction and hold it until start && !busy at an edge.
  // start stays high afterwards; the caller lowers it for a gap or a drain.
  task automatic send_header(input hdr_item_t it);
    start       <= 1'b1;
    command     <= it.cmd;
    dst_address <= it.dst;
    src_address <= it.src;
    header_id   <= it.id;
    hop_limit   <= it.hops;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_header(it);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Let every expected result come back, then a short settle before config.
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all three registers back to back (plus the spare index if asked);
  // the lifetime write carries junk in its upper bits, which must be ignored.
  task automatic program_regs(input logic [bdf_pkg::ADDR_W-1:0] node,
                              input logic [bdf_pkg::ADDR_W-1:0] bcast,
                              input logic [bdf_pkg::LIFE_W-1:0] life,
                              input bit poke_spare);
    logic [bdf_pkg::ADDR_W-1:0] life_word;
    life_word = {16'($urandom_range(0, 65535)), life};
    cfg_write <= 1'b1;
    cfg_index <= bdf_pkg::REG_NODE_ADDR;
    cfg_data  <= node;
    tracker.set_reg(bdf_pkg::REG_NODE_ADDR, node);
    @(posedge clk);
    cfg_index <= bdf_pkg::REG_BCAST_ADDR;
    cfg_data  <= bcast;
    tracker.set_reg(bdf_pkg::REG_BCAST_ADDR, bcast);
    @(posedge clk);
    cfg_index <= bdf_pkg::REG_LIFETIME;
    cfg_data  <= life_word;
    tracker.set_reg(bdf_pkg::REG_LIFETIME, life_word);
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= $urandom;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic hdr_item_t mk(logic cmd, logic [bdf_pkg::ADDR_W-1:0] dst,
                                   logic [bdf_pkg::ADDR_W-1:0] src,
                                   logic [bdf_pkg::ID_W-1:0] id,
                                   logic [bdf_pkg::TTL_W-1:0] hops);
    hdr_item_t it;
    it.cmd  = cmd;
    it.dst  = dst;
    it.src  = src;
    it.id   = id;
    it.hops = hops;
    return it;
  endfunction

  // TTL with extra weight on 0, 1 and 255
  function automatic logic [bdf_pkg::TTL_W-1:0] pick_hops();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd1;
    if (r < 25) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic fill_pool();
    logic [7:0] bk [POOL_BK];
    foreach (bk[i]) bk[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < POOL_N; i++) begin
      pool_id[i]       = 16'($urandom);
      pool_src[i]      = $urandom;
      pool_src[i][7:0] = bk[i % POOL_BK] ^ pool_id[i][7:0];
    end
  endtask

  // Mostly well-formed traffic: ticks, headers for this node, broadcasts
  // from the pool (duplicates, expiries, evictions), unicast, some noise.
  function automatic hdr_item_t random_item();
    hdr_item_t it;
    int r;
    int k;
    it = mk(bdf_pkg::CMD_HEADER, $urandom, $urandom, 16'($urandom), pick_hops());
    r = $urandom_range(0, 99);
    if (r < 12) begin
      it.cmd = bdf_pkg::CMD_TICK;
    end else if (r < 30) begin
      it.dst = tracker.own_addr;
    end else if (r < 80) begin
      it.dst = tracker.bcast_addr;
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, POOL_N - 1);
        it.src = pool_src[k];
        it.id  = pool_id[k];
      end
    end else if (r >= 95) begin
      it.cmd = 1'($urandom);
    end
    return it;
  endfunction

  task automatic run_phase(input int count, input bit gaps_on);
    for (int k = 0; k < count; k++) begin
      send_header(random_item());
      // idle bursts in alternating 40-transaction windows, calm in between
      if (gaps_on && ((k / 40) % 2 == 0) && $urandom_range(0, 99) < 30)
        pause_sender($urandom_range(1, 11));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [bdf_pkg::ADDR_W-1:0] node;
    logic [bdf_pkg::ADDR_W-1:0] bcast;
    logic [bdf_pkg::LIFE_W-1:0] life;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset config (node 0, broadcast all-ones, life 120).
    // Acceptance waits out the post-reset clearing pass on busy.
    send_header(mk(bdf_pkg::CMD_TICK,   32'h0,        32'h0,        16'h0,    8'd0));
    // header for this node, all-ones source and id, TTL 0: still delivered
    send_header(mk(bdf_pkg::CMD_HEADER, 32'h0,        32'hFFFFFFFF, 16'hFFFF, 8'd0));
    // first broadcast, then its duplicate
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h0,        16'h0,    8'd255));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h0,        16'h0,    8'd255));
    // new broadcast with TTL 1: recorded but dropped; repeat is a duplicate
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h100,      16'h0,    8'd1));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h100,      16'h0,    8'd2));
    send_header(mk(bdf_pkg::CMD_TICK,   32'h0,        32'h0,        16'h0,    8'd0));
    // fill the rest of bucket 0 (TTL 0, then TTL 2)
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h200,      16'h0,    8'd0));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h00FF, 8'd2));
    send_header(mk(bdf_pkg::CMD_TICK,   32'h0,        32'h0,        16'h0,    8'd0));
    // bucket full: oldest way goes, lowest way on an age tie
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h300,      16'h0,    8'd100));
    // evicted pair comes back as new and evicts in turn
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h0,        16'h0,    8'd10));
    // unicast with TTL at both ends and around one
    send_header(mk(bdf_pkg::CMD_HEADER, 32'h12345678, 32'hA5A5A5A5, 16'h5A5A, 8'd255));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'h12345678, 32'hA5A5A5A5, 16'h5A5A, 8'd2));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'h12345678, 32'hA5A5A5A5, 16'h5A5A, 8'd1));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'h12345678, 32'hA5A5A5A5, 16'h5A5A, 8'd0));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'h100,      16'h0,    8'd50));
    // tick carrying header-looking fields
    send_header(mk(bdf_pkg::CMD_TICK,   32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'd255));
    send_header(mk(bdf_pkg::CMD_HEADER, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'd255));
    drain();

    // Random phases, each under its own config; the drain before every
    // reprogramming also holds the sender until all results are back.
    for (int p = 0; p < 6; p++) begin
      node  = $urandom;
      bcast = $urandom;
      case (p)
        0: life = 16'd3;
        1: begin
          bcast = node;            // node check must win over broadcast
          life  = 16'd0;
        end
        2: begin
          node  = 32'h0;
          bcast = 32'hFFFFFFFF;
          life  = 16'hFFFF;
        end
        3: begin
          node  = 32'hFFFFFFFF;
          bcast = 32'h0;
          life  = 16'd1;
        end
        4: life = 16'($urandom_range(0, 10));
        default: life = 16'd2;
      endcase
      program_regs(node, bcast, life, p == 4);
      fill_pool();
      run_phase(160, p != 5);    // last phase runs back to back
      drain();
    end

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("broadcast_duplicate_filter_unit_test: clean");
    else
      $display("broadcast_duplicate_filter_unit_test: errors");
    $finish;
  end

endmodule
